[rtl/eip_pkg.sv]
package eip_pkg;

  // Frame capture limit; bytes past it are dropped
  localparam int MAX_FRAME_BYTES = 16384;
  localparam int CNT_W = 15;

  localparam logic [CNT_W-1:0] ETH_TYPE_POS  = CNT_W'(12);
  localparam logic [CNT_W-1:0] ETH_HDR_BYTES = CNT_W'(14);
  localparam logic [CNT_W-1:0] TAG_BYTES     = CNT_W'(4);
  localparam logic [CNT_W-1:0] UDP_HDR_BYTES = CNT_W'(8);
  localparam logic [5:0]       IP_MIN_HDR    = 6'd20;

  localparam logic [15:0] TPID_C     = 16'h8100;
  localparam logic [15:0] TPID_S     = 16'h88a8;
  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;

  typedef enum logic [1:0] {
    STAGE_ETH,
    STAGE_TAG,
    STAGE_IP,
    STAGE_OTHER
  } stage_t;

  typedef enum logic [2:0] {
    ST_WHOLE,
    ST_FIRST,
    ST_LATER,
    ST_TRUNC,
    ST_NOT_IPV4,
    ST_BAD_IP,
    ST_NOT_UDP,
    ST_BAD_UDP
  } status_t;

  // Everything captured from one frame
  typedef struct packed {
    stage_t            stage;
    logic [CNT_W-1:0]  byte_count;
    logic [CNT_W-1:0]  network_start;
    logic [15:0]       ethertype;
    logic [3:0]        header_words;
    logic [15:0]       total_length;
    logic [15:0]       flags_and_offset;
    logic [15:0]       ident;
    logic [7:0]        protocol;
    logic [31:0]       src_addr;
    logic [31:0]       dst_addr;
    logic [31:0]       port_pair;
    logic [15:0]       udp_len;
  } rec_t;

endpackage

[rtl/eip_byte_if.sv]
interface eip_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source(output valid, frame_byte, last_byte, input ready);
  modport sink(input valid, frame_byte, last_byte, output ready);
endinterface

[rtl/eip_hdr_if.sv]
interface eip_hdr_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] source_address;
  logic [31:0] dest_address;
  logic [15:0] source_port;
  logic [15:0] dest_port;
  logic [15:0] datagram_id;
  logic [15:0] fragment_byte_offset;
  logic        more_fragments;
  logic [15:0] udp_length;
  logic [14:0] payload_start;
  logic [15:0] payload_length;

  modport source(output valid, status, source_address, dest_address, source_port,
                 dest_port, datagram_id, fragment_byte_offset, more_fragments,
                 udp_length, payload_start, payload_length, input ready);
  modport sink(input valid, status, source_address, dest_address, source_port,
               dest_port, datagram_id, fragment_byte_offset, more_fragments,
               udp_length, payload_start, payload_length, output ready);
endinterface

[rtl/eip_capture.sv]
module eip_capture (
  input  logic          clk,
  input  logic          rst,
  eip_byte_if.sink      frame,
  input  logic          rec_ready,
  output logic          rec_valid,
  output eip_pkg::rec_t rec
);

  localparam eip_pkg::rec_t REC_INIT = '{
    stage:            eip_pkg::STAGE_ETH,
    byte_count:       '0,
    network_start:    eip_pkg::ETH_HDR_BYTES,
    ethertype:        '0,
    header_words:     '0,
    total_length:     '0,
    flags_and_offset: '0,
    ident:            '0,
    protocol:         '0,
    src_addr:         '0,
    dst_addr:         '0,
    port_pair:        '0,
    udp_len:          '0
  };

  eip_pkg::rec_t st;
  eip_pkg::rec_t st_next;
  logic          accept;

  function automatic eip_pkg::stage_t pick_stage(input logic [15:0] etype);
    eip_pkg::stage_t s;
    if (etype == eip_pkg::TPID_C || etype == eip_pkg::TPID_S) begin
      s = eip_pkg::STAGE_TAG;
    end else if (etype == eip_pkg::ETYPE_IPV4) begin
      s = eip_pkg::STAGE_IP;
    end else begin
      s = eip_pkg::STAGE_OTHER;
    end
    return s;
  endfunction

  assign frame.ready = !rec_valid || rec_ready;
  assign accept      = frame.valid && frame.ready;

  // Fold the incoming byte into the frame state
  always_comb begin
    logic [eip_pkg::CNT_W-1:0] pos;
    logic [eip_pkg::CNT_W-1:0] q;
    logic [eip_pkg::CNT_W-1:0] hlen;
    logic [7:0]                b;
    logic [2:0]                u;
    logic                      in_udp;
    pos     = st.byte_count;
    b       = frame.frame_byte;
    q       = pos - st.network_start;
    hlen    = {9'b0, st.header_words, 2'b00};
    u       = q[2:0] - hlen[2:0];
    in_udp  = (hlen[5:0] >= eip_pkg::IP_MIN_HDR) && (q >= hlen)
              && (q < hlen + eip_pkg::UDP_HDR_BYTES);
    st_next = st;
    if (st.byte_count < eip_pkg::CNT_W'(eip_pkg::MAX_FRAME_BYTES)) begin
      st_next.byte_count = st.byte_count + eip_pkg::CNT_W'(1);
      unique case (st.stage)
        eip_pkg::STAGE_ETH: begin
          if (pos == eip_pkg::ETH_TYPE_POS) begin
            st_next.ethertype = {b, 8'h00};
          end
          if (pos == eip_pkg::ETH_TYPE_POS + eip_pkg::CNT_W'(1)) begin
            st_next.ethertype = {st.ethertype[15:8], b};
            st_next.stage     = pick_stage({st.ethertype[15:8], b});
          end
        end
        eip_pkg::STAGE_TAG: begin
          if (pos >= st.network_start) begin
            // inner type sits in the last two bytes of the tag
            if (q == eip_pkg::CNT_W'(2)) begin
              st_next.ethertype = {b, 8'h00};
            end
            if (q == eip_pkg::CNT_W'(3)) begin
              st_next.ethertype     = {st.ethertype[15:8], b};
              st_next.network_start = st.network_start + eip_pkg::TAG_BYTES;
              st_next.stage         = pick_stage({st.ethertype[15:8], b});
            end
          end
        end
        eip_pkg::STAGE_IP: begin
          if (pos >= st.network_start) begin
            if (q == eip_pkg::CNT_W'(0)) begin
              st_next.header_words = b[3:0];
            end else if (q == eip_pkg::CNT_W'(2) || q == eip_pkg::CNT_W'(3)) begin
              st_next.total_length = {st.total_length[7:0], b};
            end else if (q == eip_pkg::CNT_W'(4) || q == eip_pkg::CNT_W'(5)) begin
              st_next.ident = {st.ident[7:0], b};
            end else if (q == eip_pkg::CNT_W'(6) || q == eip_pkg::CNT_W'(7)) begin
              st_next.flags_and_offset = {st.flags_and_offset[7:0], b};
            end else if (q == eip_pkg::CNT_W'(9)) begin
              st_next.protocol = b;
            end else if (q >= eip_pkg::CNT_W'(12) && q < eip_pkg::CNT_W'(16)) begin
              st_next.src_addr = {st.src_addr[23:0], b};
            end else if (q >= eip_pkg::CNT_W'(16) && q < eip_pkg::CNT_W'(20)) begin
              st_next.dst_addr = {st.dst_addr[23:0], b};
            end
            // UDP header follows the IP header
            if (in_udp) begin
              if (u < 3'd4) begin
                st_next.port_pair = {st.port_pair[23:0], b};
              end else if (u == 3'd4 || u == 3'd5) begin
                st_next.udp_len = {st.udp_len[7:0], b};
              end
            end
          end
        end
        default: begin
          // other ethertype: only count bytes
        end
      endcase
    end
  end

  // Hold frame state; hand off the record on the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= REC_INIT;
      rec_valid <= 1'b0;
    end else begin
      if (rec_ready) begin
        rec_valid <= 1'b0;
      end
      if (accept) begin
        if (frame.last_byte) begin
          rec       <= st_next;
          rec_valid <= 1'b1;
          st        <= REC_INIT;
        end else begin
          st <= st_next;
        end
      end
    end
  end

endmodule

[rtl/eip_check.sv]
module eip_check (
  input  logic          clk,
  input  logic          rst,
  input  logic          rec_valid,
  input  eip_pkg::rec_t rec,
  output logic          rec_ready,
  eip_hdr_if.source     header
);

  eip_pkg::status_t status_next;
  logic [31:0]      src_next;
  logic [31:0]      dst_next;
  logic [15:0]      sport_next;
  logic [15:0]      dport_next;
  logic [15:0]      id_next;
  logic [15:0]      foff_next;
  logic             mf_next;
  logic [15:0]      ulen_next;
  logic [14:0]      pstart_next;
  logic [15:0]      plen_next;

  assign rec_ready = !header.valid || header.ready;

  // Run the frame checks in order and form the result fields
  always_comb begin
    logic [5:0]  hlen;
    logic [15:0] len16;
    logic [15:0] ns16;
    logic [16:0] ns_total;
    logic [15:0] ipay;
    logic [15:0] foff;
    logic [15:0] udp_min;
    logic        mf;
    hlen        = {rec.header_words, 2'b00};
    len16       = {1'b0, rec.byte_count};
    ns16        = {1'b0, rec.network_start};
    ns_total    = {2'b0, rec.network_start} + {1'b0, rec.total_length};
    ipay        = rec.total_length - {10'b0, hlen};
    foff        = {rec.flags_and_offset[12:0], 3'b000};
    mf          = rec.flags_and_offset[13];
    udp_min     = (rec.udp_len < ipay) ? rec.udp_len : ipay;
    status_next = eip_pkg::ST_TRUNC;
    src_next    = '0;
    dst_next    = '0;
    sport_next  = '0;
    dport_next  = '0;
    id_next     = '0;
    foff_next   = '0;
    mf_next     = 1'b0;
    ulen_next   = '0;
    pstart_next = '0;
    plen_next   = '0;
    priority if (rec.stage == eip_pkg::STAGE_ETH || rec.stage == eip_pkg::STAGE_TAG) begin
      status_next = eip_pkg::ST_TRUNC;
    end else if (rec.stage != eip_pkg::STAGE_IP) begin
      status_next = eip_pkg::ST_NOT_IPV4;
    end else if (len16 < ns16 + 16'd20) begin
      status_next = eip_pkg::ST_TRUNC;
    end else if (hlen < eip_pkg::IP_MIN_HDR) begin
      status_next = eip_pkg::ST_BAD_IP;
    end else if (len16 < ns16 + {10'b0, hlen}) begin
      status_next = eip_pkg::ST_TRUNC;
    end else if (rec.total_length < {10'b0, hlen}) begin
      status_next = eip_pkg::ST_BAD_IP;
    end else if (rec.protocol != eip_pkg::PROTO_UDP) begin
      status_next = eip_pkg::ST_NOT_UDP;
    end else if (ns_total > {2'b0, rec.byte_count}) begin
      status_next = eip_pkg::ST_TRUNC;
    end else if (foff == 16'd0 && (ipay < 16'd8 || rec.udp_len < 16'd8)) begin
      status_next = eip_pkg::ST_BAD_UDP;
    end else if (foff == 16'd0 && mf && rec.udp_len == 16'd8) begin
      status_next = eip_pkg::ST_BAD_UDP;
    end else begin
      src_next  = rec.src_addr;
      dst_next  = rec.dst_addr;
      id_next   = rec.ident;
      foff_next = foff;
      mf_next   = mf;
      if (foff == 16'd0) begin
        status_next = mf ? eip_pkg::ST_FIRST : eip_pkg::ST_WHOLE;
        sport_next  = rec.port_pair[31:16];
        dport_next  = rec.port_pair[15:0];
        ulen_next   = rec.udp_len;
        pstart_next = rec.network_start + {9'b0, hlen} + eip_pkg::UDP_HDR_BYTES;
        plen_next   = udp_min - 16'd8;
      end else begin
        status_next = eip_pkg::ST_LATER;
        pstart_next = rec.network_start + {9'b0, hlen};
        plen_next   = ipay;
      end
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      header.valid <= 1'b0;
    end else begin
      if (header.ready) begin
        header.valid <= 1'b0;
      end
      if (rec_valid && rec_ready) begin
        header.valid                <= 1'b1;
        header.status               <= status_next;
        header.source_address       <= src_next;
        header.dest_address         <= dst_next;
        header.source_port          <= sport_next;
        header.dest_port            <= dport_next;
        header.datagram_id          <= id_next;
        header.fragment_byte_offset <= foff_next;
        header.more_fragments       <= mf_next;
        header.udp_length           <= ulen_next;
        header.payload_start        <= pstart_next;
        header.payload_length       <= plen_next;
      end
    end
  end

endmodule

[rtl/ethernet_ipv4_udp_header_parser.sv]
// Ethernet / VLAN / IPv4 / UDP header parser.
// The frame channel carries one frame byte per item, with last_byte set on
// the final byte. Any run of 0x8100 or 0x88a8 tags is skipped; the IPv4 and
// UDP header fields are captured as the bytes go by. Bytes past 16384 are
// counted as absent, like a snap length.
// The header channel carries one item per frame: a status code, the address,
// port, fragment fields and the payload start and length. Fields that do not
// apply to the status read 0.
// Throughput: one byte per cycle while the header receiver keeps up,
// including back-to-back frames. The last byte closes the frame record in
// the capture register; the checks on that record are then registered into
// the header output register, from which the result item is valid.
// When the header receiver stalls, a finished result waits in the output
// register, one more frame record waits behind it, and frame.ready drops
// only once both are full.
// Reset clears the frame state and drops any pending result.
module ethernet_ipv4_udp_header_parser (
  input  logic       clk,
  input  logic       rst,
  eip_byte_if.sink   frame,
  eip_hdr_if.source  header
);

  eip_pkg::rec_t rec;
  logic          rec_valid;
  logic          rec_ready;

  // Byte-by-byte field capture
  eip_capture u_capture (
    .clk       (clk),
    .rst       (rst),
    .frame     (frame),
    .rec_ready (rec_ready),
    .rec_valid (rec_valid),
    .rec       (rec)
  );

  // Frame checks and result register
  eip_check u_check (
    .clk       (clk),
    .rst       (rst),
    .rec_valid (rec_valid),
    .rec       (rec),
    .rec_ready (rec_ready),
    .header    (header)
  );

endmodule
